// ===== rtl/msrh_pkg.sv =====
// ----------------------------------------------------------------------------
// Moving sphere ray hit package
// Shared widths, register indexes, payload types and saturation helper.
// ----------------------------------------------------------------------------
package msrh_pkg;

  localparam int TimeStartDef = 0;
  localparam int TimeEndDef   = 65536;

  localparam int AddrW    = 5;
  localparam int InDataW  = 288;
  localparam int OutDataW = 232;
  localparam int RadW     = 31;
  localparam int TNumW    = 50;
  localparam int NNumW    = 48;
  localparam int RootW    = 32;
  localparam int QueueDepth = 4;

  localparam logic [2:0] RegStartX  = 3'd0;
  localparam logic [2:0] RegStartY  = 3'd1;
  localparam logic [2:0] RegStartZ  = 3'd2;
  localparam logic [2:0] RegEndX    = 3'd3;
  localparam logic [2:0] RegEndY    = 3'd4;
  localparam logic [2:0] RegEndZ    = 3'd5;
  localparam logic [2:0] RegRadius  = 3'd6;

  localparam logic [RadW-1:0] RadiusReset = 31'd65536;

  typedef logic signed [31:0] q16_t;
  typedef logic [2:0][31:0] vec_t;

  typedef struct packed {
    vec_t          c0;
    vec_t          c1;
    logic [RadW-1:0] rad;
  } cfg_t;

  typedef struct packed {
    vec_t o;
    vec_t d;
    vec_t ctr;
    q16_t lo;
    q16_t hi;
  } ray_t;

  typedef struct packed {
    ray_t ray;
    q16_t a;
    q16_t hb;
    q16_t cc;
  } quad_t;

  function automatic q16_t sat32(input logic signed [65:0] x);
    q16_t r;
    if (x > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = $signed(x[31:0]);
    end
    return r;
  endfunction

endpackage

// ===== rtl/msrh_delay.sv =====
// ----------------------------------------------------------------------------
// Delay line
// Carries a valid bit and a side payload alongside a pipelined unit.
// ----------------------------------------------------------------------------
module msrh_delay #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         vin,
  input  logic [W-1:0] din,
  output logic         vout,
  output logic [W-1:0] dout
);

  logic [N-1:0] vld;
  logic [W-1:0] data_q [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld[0] <= vin;
      for (int i = 1; i < N; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_q[0] <= din;
      for (int i = 1; i < N; i++) data_q[i] <= data_q[i-1];
    end
  end

  assign vout = vld[N-1];
  assign dout = data_q[N-1];

endmodule

// ===== rtl/msrh_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined divider
// Unsigned restoring division, one quotient bit per stage, NW stages.
// ----------------------------------------------------------------------------
module msrh_div #(
  parameter int NW = 50,
  parameter int DW = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] num_q [NW];
  logic [DW-1:0] den_q [NW];
  logic [NW-1:0] quo_q [NW];

  for (genvar s = 0; s < NW; s++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [NW-1:0] num_in;
    logic [NW-1:0] quo_in;
    logic [DW:0]   sh;
    logic [DW:0]   df;
    logic          take;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den;
      assign num_in = num;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign num_in = num_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign sh   = {rem_in, num_in[NW-1]};
    assign take = sh >= {1'b0, den_in};
    assign df   = sh - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= take ? df[DW-1:0] : sh[DW-1:0];
        num_q[s] <= {num_in[NW-2:0], 1'b0};
        den_q[s] <= den_in;
        quo_q[s] <= {quo_in[NW-2:0], take};
      end
    end
  end

  assign quo = quo_q[NW-1];

endmodule

// ===== rtl/msrh_sqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined square root
// Floor square root of a 2*RW bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module msrh_sqrt #(
  parameter int RW = 32
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] val,
  output logic [RW-1:0]   root
);

  localparam int VW = 2 * RW;
  localparam int SW = RW + 4;

  logic [SW-1:0] rem_q [RW];
  logic [VW-1:0] val_q [RW];
  logic [RW-1:0] res_q [RW];

  for (genvar s = 0; s < RW; s++) begin : g_step
    logic [SW-1:0] rem_in;
    logic [VW-1:0] val_in;
    logic [RW-1:0] res_in;
    logic [SW-1:0] sh;
    logic [SW-1:0] trial;
    logic          take;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign val_in = val;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign val_in = val_q[s-1];
      assign res_in = res_q[s-1];
    end

    assign sh    = {rem_in[SW-3:0], val_in[VW-1:VW-2]};
    assign trial = SW'({res_in, 2'b01});
    assign take  = sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= take ? (sh - trial) : sh;
        val_q[s] <= {val_in[VW-3:0], 2'b00};
        res_q[s] <= {res_in[RW-2:0], take};
      end
    end
  end

  assign root = res_q[RW-1];

endmodule

// ===== rtl/msrh_fifo.sv =====
// ----------------------------------------------------------------------------
// Decoupling queue
// Short register queue between front and back; Depth a power of two.
// ----------------------------------------------------------------------------
module msrh_fifo #(
  parameter int W     = 8,
  parameter int Depth = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  localparam int PW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);

  logic [W-1:0]  mem [Depth];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign in_ready  = count != CW'(Depth);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end

endmodule

// ===== rtl/msrh_front.sv =====
// ----------------------------------------------------------------------------
// Front pipeline
// Accepts rays, places the moving centre and forms the quadratic terms.
// ----------------------------------------------------------------------------
module msrh_front import msrh_pkg::*; #(
  parameter int TIME_START = TimeStartDef,
  parameter int TIME_END   = TimeEndDef
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [InDataW-1:0] s_tdata,
  output logic               push_valid,
  input  logic               push_ready,
  output quad_t              push_data
);

  localparam longint Span    = longint'(TIME_END) - longint'(TIME_START);
  localparam bit     HasSpan = (Span != 0);
  localparam bit     SpanNeg = (Span < 0);
  localparam longint SpanDen = HasSpan ? (SpanNeg ? -Span : Span) : 64'sd1;
  localparam int     RecipK  = 63 + $clog2(SpanDen);
  localparam logic [127:0] Recip =
    ((128'd1 << RecipK) + 128'(SpanDen) - 128'd1) / 128'(SpanDen);
  localparam logic [31:0] RecipR0 = Recip[31:0];
  localparam logic [31:0] RecipR1 = Recip[63:32];
  localparam bit          RecipR2 = Recip[64];

  logic              adv;
  logic [10:0]       vld;
  ray_t              ray0, ray1, ray2, ray3, ray4, ray5, ray6, ray7, ray8, ray9;
  q16_t              tm0;
  q16_t              dt1;
  vec_t              dif1;
  logic signed [63:0] prod2 [3];
  logic [62:0]       nmag3 [3];
  logic [2:0]        neg3, neg4, neg5;
  logic [63:0]       pp4 [3][4];
  logic [62:0]       pt4 [3];
  logic [127:0]      acc5 [3];
  logic [63:0]       qmag5 [3];
  logic signed [63:0] quo6 [3];
  vec_t              oc8;
  logic signed [63:0] dd9 [3];
  logic signed [63:0] od9 [3];
  logic signed [63:0] oo9 [3];
  logic [61:0]       rr9;
  quad_t             quad10;

  assign adv        = !vld[10] || push_ready;
  assign s_tready   = adv;
  assign push_valid = vld[10];
  assign push_data  = quad10;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[9:0], s_tvalid};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) qmag5[i] = 64'(acc5[i] >> RecipK);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ray0.o[i]   <= s_tdata[32*i +: 32];
        ray0.d[i]   <= s_tdata[96+32*i +: 32];
        ray0.ctr[i] <= '0;
      end
      tm0     <= $signed(s_tdata[223:192]);
      ray0.lo <= $signed(s_tdata[255:224]);
      ray0.hi <= $signed(s_tdata[287:256]);

      dt1  <= sat32(66'($signed(tm0)) - 66'(TIME_START));
      ray1 <= ray0;
      for (int i = 0; i < 3; i++) begin
        dif1[i] <= sat32(66'($signed(cfg.c1[i])) - 66'($signed(cfg.c0[i])));
      end

      ray2 <= ray1;
      for (int i = 0; i < 3; i++) prod2[i] <= $signed(dt1) * $signed(dif1[i]);

      ray3 <= ray2;
      for (int i = 0; i < 3; i++) begin
        nmag3[i] <= 63'(prod2[i][63] ? -prod2[i] : prod2[i]);
        neg3[i]  <= prod2[i][63] ^ SpanNeg;
      end

      ray4 <= ray3;
      neg4 <= neg3;
      for (int i = 0; i < 3; i++) begin
        pp4[i][0] <= 64'(nmag3[i][31:0]) * 64'(RecipR0);
        pp4[i][1] <= 64'(nmag3[i][31:0]) * 64'(RecipR1);
        pp4[i][2] <= 64'(nmag3[i][62:32]) * 64'(RecipR0);
        pp4[i][3] <= 64'(nmag3[i][62:32]) * 64'(RecipR1);
        pt4[i]    <= RecipR2 ? nmag3[i] : '0;
      end

      ray5 <= ray4;
      neg5 <= neg4;
      for (int i = 0; i < 3; i++) begin
        acc5[i] <= 128'(pp4[i][0]) + (128'(pp4[i][1]) << 32) + (128'(pp4[i][2]) << 32)
                   + (128'(pp4[i][3]) << 64) + (128'(pt4[i]) << 64);
      end

      ray6 <= ray5;
      for (int i = 0; i < 3; i++) begin
        quo6[i] <= !HasSpan ? 64'sd0
                 : (neg5[i] ? -$signed(qmag5[i]) : $signed(qmag5[i]));
      end

      ray7.o  <= ray6.o;
      ray7.d  <= ray6.d;
      ray7.lo <= ray6.lo;
      ray7.hi <= ray6.hi;
      for (int i = 0; i < 3; i++) begin
        ray7.ctr[i] <= sat32(66'($signed(cfg.c0[i])) + 66'(quo6[i]));
      end

      ray8 <= ray7;
      for (int i = 0; i < 3; i++) begin
        oc8[i] <= sat32(66'($signed(ray7.o[i])) - 66'($signed(ray7.ctr[i])));
      end

      ray9 <= ray8;
      rr9  <= 62'(cfg.rad) * 62'(cfg.rad);
      for (int i = 0; i < 3; i++) begin
        dd9[i] <= $signed(ray8.d[i]) * $signed(ray8.d[i]);
        od9[i] <= $signed(oc8[i]) * $signed(ray8.d[i]);
        oo9[i] <= $signed(oc8[i]) * $signed(oc8[i]);
      end

      quad10.ray <= ray9;
      quad10.a   <= sat32(66'(dd9[0] >>> 16) + 66'(dd9[1] >>> 16) + 66'(dd9[2] >>> 16));
      quad10.hb  <= sat32(66'(od9[0] >>> 16) + 66'(od9[1] >>> 16) + 66'(od9[2] >>> 16));
      quad10.cc  <= sat32(66'(oo9[0] >>> 16) + 66'(oo9[1] >>> 16) + 66'(oo9[2] >>> 16)
                          - $signed({20'b0, rr9[61:16]}));
    end
  end

endmodule

// ===== rtl/msrh_back.sv =====
// ----------------------------------------------------------------------------
// Back pipeline
// Solves the quadratic, picks the root, forms the hit point and the normal.
// ----------------------------------------------------------------------------
module msrh_back import msrh_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [RadW-1:0]     rad,
  input  logic                in_valid,
  output logic                in_ready,
  input  quad_t               in_data,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,
  output logic                m_tuser
);

  typedef struct packed {
    logic ok;
    q16_t hb;
    q16_t a;
    ray_t ray;
  } sq_side_t;

  typedef struct packed {
    logic ok;
    logic s1;
    logic s2;
    ray_t ray;
  } td_side_t;

  typedef struct packed {
    logic       found;
    logic [2:0] sgn;
    q16_t       t;
    vec_t       p;
    vec_t       d;
  } nd_side_t;

  logic en;
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9;
  logic v_sq, v_td, v_nd;

  logic signed [63:0] hbhb1, acc1;
  q16_t               hb1, a1;
  ray_t               ray1;

  logic signed [64:0] disc;
  logic [63:0]        sq_in2;
  sq_side_t           side2, side_sq;
  logic [RootW-1:0]   root;

  logic signed [34:0] n1, n2;
  logic signed [34:0] abs1, abs2;
  logic [TNumW-1:0]   mag1_3, mag2_3;
  logic [RadW-1:0]    den3;
  td_side_t           side3, side_td;
  logic [TNumW-1:0]   q1, q2;

  logic signed [50:0] t1, t2, lo51, hi51;
  logic               in1, in2;
  logic               found4, found5, found6;
  q16_t               t4, t5, t6;
  ray_t               ray4, ray5, ray6;
  logic signed [63:0] td5 [3];
  vec_t               p6;

  logic signed [32:0] df [3];
  logic signed [32:0] dabs [3];
  logic [NNumW-1:0]   mag7 [3];
  logic [RadW-1:0]    den7;
  nd_side_t           side7, side_nd;
  logic [NNumW-1:0]   qn [3];

  logic               found8, found9;
  q16_t               t8, t9;
  vec_t               p8, p9, d8, nrm8, nrm9;
  logic signed [63:0] pr9 [3];

  logic signed [65:0] dn;
  logic               front;
  vec_t               nfin;

  assign en       = !m_tvalid || m_tready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9, m_tvalid} <= '0;
    end else if (en) begin
      v1       <= in_valid;
      v2       <= v1;
      v3       <= v_sq;
      v4       <= v_td;
      v5       <= v4;
      v6       <= v5;
      v7       <= v6;
      v8       <= v_nd;
      v9       <= v8;
      m_tvalid <= v9;
    end
  end

  assign disc = 65'(hbhb1) - 65'(acc1);

  always_ff @(posedge clk) begin
    if (en) begin
      hbhb1 <= $signed(in_data.hb) * $signed(in_data.hb);
      acc1  <= $signed(in_data.a) * $signed(in_data.cc);
      hb1   <= in_data.hb;
      a1    <= in_data.a;
      ray1  <= in_data.ray;

      side2.ok  <= (disc > 65'sd0) && ($signed(a1) > 32'sd0);
      side2.hb  <= hb1;
      side2.a   <= a1;
      side2.ray <= ray1;
      sq_in2    <= disc[63:0];
    end
  end

  msrh_sqrt #(.RW(RootW)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .val  (sq_in2),
    .root (root)
  );

  msrh_delay #(.W($bits(sq_side_t)), .N(RootW)) u_sq_dly (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (v2),
    .din  (side2),
    .vout (v_sq),
    .dout (side_sq)
  );

  assign n1   = -35'($signed(side_sq.hb)) - $signed({3'b0, root});
  assign n2   = -35'($signed(side_sq.hb)) + $signed({3'b0, root});
  assign abs1 = n1[34] ? -n1 : n1;
  assign abs2 = n2[34] ? -n2 : n2;

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_3    <= {abs1[33:0], 16'b0};
      mag2_3    <= {abs2[33:0], 16'b0};
      den3      <= side_sq.a[RadW-1:0];
      side3.ok  <= side_sq.ok;
      side3.s1  <= n1[34];
      side3.s2  <= n2[34];
      side3.ray <= side_sq.ray;
    end
  end

  msrh_div #(.NW(TNumW), .DW(RadW)) u_div_t1 (
    .clk (clk), .en (en), .num (mag1_3), .den (den3), .quo (q1)
  );

  msrh_div #(.NW(TNumW), .DW(RadW)) u_div_t2 (
    .clk (clk), .en (en), .num (mag2_3), .den (den3), .quo (q2)
  );

  msrh_delay #(.W($bits(td_side_t)), .N(TNumW)) u_td_dly (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (v3),
    .din  (side3),
    .vout (v_td),
    .dout (side_td)
  );

  assign t1   = side_td.s1 ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
  assign t2   = side_td.s2 ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
  assign lo51 = 51'($signed(side_td.ray.lo));
  assign hi51 = 51'($signed(side_td.ray.hi));
  assign in1  = (t1 < hi51) && (t1 > lo51);
  assign in2  = (t2 < hi51) && (t2 > lo51);

  always_ff @(posedge clk) begin
    if (en) begin
      found4 <= side_td.ok && (in1 || in2);
      t4     <= in1 ? $signed(t1[31:0]) : $signed(t2[31:0]);
      ray4   <= side_td.ray;

      found5 <= found4;
      t5     <= t4;
      ray5   <= ray4;
      for (int i = 0; i < 3; i++) td5[i] <= $signed(t4) * $signed(ray4.d[i]);

      found6 <= found5;
      t6     <= t5;
      ray6   <= ray5;
      for (int i = 0; i < 3; i++) begin
        p6[i] <= sat32(66'($signed(ray5.o[i])) + 66'(td5[i] >>> 16));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      df[i]   = 33'($signed(p6[i])) - 33'($signed(ray6.ctr[i]));
      dabs[i] = df[i][32] ? -df[i] : df[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag7[i]      <= {dabs[i][31:0], 16'b0};
        side7.sgn[i] <= df[i][32];
      end
      den7        <= (rad == '0) ? RadW'(1) : rad;
      side7.found <= found6;
      side7.t     <= t6;
      side7.p     <= p6;
      side7.d     <= ray6.d;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_ndiv
    msrh_div #(.NW(NNumW), .DW(RadW)) u_div_n (
      .clk (clk), .en (en), .num (mag7[g]), .den (den7), .quo (qn[g])
    );
  end

  msrh_delay #(.W($bits(nd_side_t)), .N(NNumW)) u_nd_dly (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (v7),
    .din  (side7),
    .vout (v_nd),
    .dout (side_nd)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      found8 <= side_nd.found;
      t8     <= side_nd.t;
      p8     <= side_nd.p;
      d8     <= side_nd.d;
      for (int i = 0; i < 3; i++) begin
        nrm8[i] <= side_nd.sgn[i] ? sat32(-$signed({18'b0, qn[i]}))
                                  : sat32($signed({18'b0, qn[i]}));
      end

      found9 <= found8;
      t9     <= t8;
      p9     <= p8;
      nrm9   <= nrm8;
      for (int i = 0; i < 3; i++) pr9[i] <= $signed(d8[i]) * $signed(nrm8[i]);
    end
  end

  always_comb begin
    dn    = 66'(pr9[0] >>> 16) + 66'(pr9[1] >>> 16) + 66'(pr9[2] >>> 16);
    front = dn < 66'sd0;
    for (int i = 0; i < 3; i++) begin
      nfin[i] = front ? nrm9[i] : sat32(-66'($signed(nrm9[i])));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= found9;
      m_tdata <= found9 ? {7'b0, front, nfin[2], nfin[1], nfin[0], p9[2], p9[1], p9[0], t9}
                        : '0;
    end
  end

endmodule

// ===== rtl/moving_sphere_ray_hit_unit.sv =====
// ----------------------------------------------------------------------------
// Moving sphere ray hit unit
// Intersects one ray per cycle with a sphere moving between two centres.
// ----------------------------------------------------------------------------
// Rays enter on the s_ channel, one ray per transaction; results leave on the
// m_ channel in the same order, one result per ray. m_tuser flags a hit; on
// a miss every data field is zero. Sphere centres and radius must be written
// through the APB port while no ray is in flight; the unit does not enforce
// this. Throughput is one ray per cycle while the output is not stalled. A
// ray passes through 11 front stages and the queue, then 140 back stages set
// by the 32 step square root and the 50 and 48 step restoring dividers.
// Reset clears the pipeline valids and the queue, and loads the centres with
// zero and the radius with 1.0. When m_tready is low and m_tvalid is high the
// back pipeline holds; the front keeps accepting until the four entry queue
// fills, then drops s_tready.
// ----------------------------------------------------------------------------
module moving_sphere_ray_hit_unit import msrh_pkg::*; #(
  parameter int TIME_START = TimeStartDef,
  parameter int TIME_END   = TimeEndDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                s_tvalid,
  output logic                s_tready,
  // origin x,y,z, dir x,y,z, time, t_lower, t_upper
  input  logic [InDataW-1:0]  s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // hit_t, point x,y,z, normal x,y,z, front_face, zero pad
  output logic [OutDataW-1:0] m_tdata,
  // hit_found
  output logic                m_tuser
);

  cfg_t       cfg;
  logic [2:0] reg_idx;
  logic       q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  quad_t      q_in_data, q_out_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.c0  <= '0;
      cfg.c1  <= '0;
      cfg.rad <= RadiusReset;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        RegStartX: cfg.c0[0] <= pwdata;
        RegStartY: cfg.c0[1] <= pwdata;
        RegStartZ: cfg.c0[2] <= pwdata;
        RegEndX:   cfg.c1[0] <= pwdata;
        RegEndY:   cfg.c1[1] <= pwdata;
        RegEndZ:   cfg.c1[2] <= pwdata;
        RegRadius: cfg.rad   <= pwdata[RadW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegStartX: prdata = cfg.c0[0];
      RegStartY: prdata = cfg.c0[1];
      RegStartZ: prdata = cfg.c0[2];
      RegEndX:   prdata = cfg.c1[0];
      RegEndY:   prdata = cfg.c1[1];
      RegEndZ:   prdata = cfg.c1[2];
      RegRadius: prdata = {1'b0, cfg.rad};
      default:   prdata = '0;
    endcase
  end

  msrh_front #(.TIME_START(TIME_START), .TIME_END(TIME_END)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_data  (q_in_data)
  );

  msrh_fifo #(.W($bits(quad_t)), .Depth(QueueDepth)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_in_valid),
    .in_ready  (q_in_ready),
    .in_data   (q_in_data),
    .out_valid (q_out_valid),
    .out_ready (q_out_ready),
    .out_data  (q_out_data)
  );

  msrh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .rad      (cfg.rad),
    .in_valid (q_out_valid),
    .in_ready (q_out_ready),
    .in_data  (q_out_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== tb/moving_sphere_ray_hit_unit_test.sv =====
// ----------------------------------------------------------------------------
// Moving sphere ray hit unit testbench
// Streams rays into the intersector under random valid and ready idling,
// predicts each result with a local fixed-point sphere solver, and compares
// hit flag, t, point, normal and face flag result by result. Sphere centres
// and radius are rewritten over APB between phases while the unit is idle.
// ----------------------------------------------------------------------------
module moving_sphere_ray_hit_unit_test;
  import msrh_pkg::*;

  localparam int Latency   = 200;
  localparam int WatchLimit = 20000;
  localparam int NumRandom = 550;

  typedef struct {
    logic signed [31:0] o [3];
    logic signed [31:0] d [3];
    logic signed [31:0] tm;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } ray_item_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] t;
    logic signed [31:0] p [3];
    logic signed [31:0] n [3];
    logic               front;
  } hit_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InDataW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic m_tuser;

  moving_sphere_ray_hit_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [31:0] center_start [3];
  logic signed [31:0] center_end [3];
  logic [30:0] radius;
  hit_rec_t hits_pending [$];
  int errors = 0;
  int idle_pct = 32;
  int quiet_cycles = 0;
  bit stim_done = 1'b0;

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint fl16(longint x);
    return x >>> 16;
  endfunction

  function automatic longint root64(longint v);
    longint unsigned res, b, x;
    res = 0;
    b = 64'd1 << 62;
    x = v;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic hit_rec_t solve_sphere(ray_item_t r);
    hit_rec_t h;
    longint ctr [3], oc [3], o, d, p, nm [3];
    longint span, dt, a, hb, cc, disc, rt, t, dn, rad;
    bit found;
    h.hit = 0; h.t = 0; h.front = 0;
    for (int i = 0; i < 3; i++) begin h.p[i] = 0; h.n[i] = 0; end
    span = longint'(TimeEndDef) - longint'(TimeStartDef);
    dt = clamp32(longint'(r.tm) - TimeStartDef);
    rad = longint'(radius);
    a = 0; hb = 0; cc = 0;
    for (int i = 0; i < 3; i++) begin
      ctr[i] = center_start[i];
      if (span != 0)
        ctr[i] = clamp32(center_start[i] +
                 (dt * clamp32(longint'(center_end[i]) - center_start[i])) / span);
      oc[i] = clamp32(longint'(r.o[i]) - ctr[i]);
      d = r.d[i];
      a += fl16(d * d);
      hb += fl16(oc[i] * d);
      cc += fl16(oc[i] * oc[i]);
    end
    a = clamp32(a);
    hb = clamp32(hb);
    cc = clamp32(cc - fl16(rad * rad));
    disc = hb * hb - a * cc;
    if (disc <= 0 || a <= 0) return h;
    rt = root64(disc);
    found = 0;
    t = ((-hb - rt) * 65536) / a;
    if (t < r.hi && t > r.lo) found = 1;
    else begin
      t = ((-hb + rt) * 65536) / a;
      if (t < r.hi && t > r.lo) found = 1;
    end
    if (!found) return h;
    if (rad == 0) rad = 1;
    dn = 0;
    for (int i = 0; i < 3; i++) begin
      o = r.o[i];
      d = r.d[i];
      p = clamp32(o + fl16(t * d));
      h.p[i] = p;
      nm[i] = clamp32(((p - ctr[i]) * 65536) / rad);
      dn += fl16(d * nm[i]);
    end
    h.front = dn < 0;
    for (int i = 0; i < 3; i++) h.n[i] = h.front ? nm[i] : clamp32(-nm[i]);
    h.hit = 1;
    h.t = t;
    return h;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1; paddr = AddrW'({idx, 2'b00}); pwdata = val;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    if (idx < RegRadius) begin
      if (idx < RegEndX) center_start[idx] = val;
      else center_end[idx - RegEndX] = val;
    end else begin
      radius = val[30:0];
    end
  endtask

  task automatic send_ray(ray_item_t r);
    logic [InDataW-1:0] pk;
    pk = '0;
    for (int i = 0; i < 3; i++) begin
      pk[32*i +: 32] = r.o[i];
      pk[96 + 32*i +: 32] = r.d[i];
    end
    pk[192 +: 32] = r.tm;
    pk[224 +: 32] = r.lo;
    pk[256 +: 32] = r.hi;
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = pk;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    hits_pending.push_back(solve_sphere(r));
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic drain;
    while (hits_pending.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
      2: return 32'($signed($urandom_range(0, 65536)) - 32768);
      default: return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
    endcase
  endfunction

  // aim most rays at the sphere so hits are common
  function automatic ray_item_t rnd_ray();
    ray_item_t r;
    for (int i = 0; i < 3; i++) begin
      r.o[i] = rnd_val();
      r.d[i] = ($urandom_range(9) == 0) ? $urandom : 32'($signed($urandom_range(0,
               4 * 65536)) - 2 * 65536);
    end
    if ($urandom_range(3) != 0) begin
      for (int i = 0; i < 3; i++)
        r.d[i] = 32'($signed((center_start[i] >>> 1) + (center_end[i] >>> 1)) -
                 $signed(r.o[i] >>> 1) + $signed($urandom_range(0, 32768)) - 16384);
      r.o[0] = r.o[0];
    end
    r.tm = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 65536);
    r.lo = ($urandom_range(7) == 0) ? $urandom : 32'($signed($urandom_range(0, 256)) - 128);
    r.hi = ($urandom_range(7) == 0) ? $urandom : 32'h7fffffff - $urandom_range(0, 255);
    return r;
  endfunction

  function automatic ray_item_t mk(int ox, int oy, int oz, int dx, int dy, int dz,
                                   int tm, int lo, int hi);
    ray_item_t r;
    r.o[0] = ox; r.o[1] = oy; r.o[2] = oz;
    r.d[0] = dx; r.d[1] = dy; r.d[2] = dz;
    r.tm = tm; r.lo = lo; r.hi = hi;
    return r;
  endfunction

  localparam int One = 65536;
  localparam int MaxI = 32'h7fffffff;
  localparam int MinI = 32'h80000000;

  ray_item_t directed [$];

  always @(posedge clk) begin
    hit_rec_t w;
    hit_rec_t g;
    if (!rst && m_tvalid && m_tready) begin
      g.hit = m_tuser;
      g.t = m_tdata[31:0];
      for (int i = 0; i < 3; i++) begin
        g.p[i] = m_tdata[32 + 32*i +: 32];
        g.n[i] = m_tdata[128 + 32*i +: 32];
      end
      g.front = m_tdata[224];
      if (hits_pending.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        w = hits_pending.pop_front();
        if (g.hit !== w.hit) report_mismatch("hit_found", g.hit, w.hit);
        if (g.t !== w.t) report_mismatch("hit_t", g.t, w.t);
        for (int i = 0; i < 3; i++) begin
          if (g.p[i] !== w.p[i]) report_mismatch("point", g.p[i], w.p[i]);
          if (g.n[i] !== w.n[i]) report_mismatch("normal", g.n[i], w.n[i]);
        end
        if (g.front !== w.front) report_mismatch("front_face", g.front, w.front);
        if (m_tdata[OutDataW-1:225] !== '0) report_mismatch("pad", 1, 0);
      end
    end
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= idle_pct);

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst || psel)
      quiet_cycles <= 0;
    else if (hits_pending.size() != 0 || (s_tvalid && !stim_done))
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 3; i++) begin center_start[i] = 0; center_end[i] = 0; end
    radius = RadiusReset;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // after reset: unit sphere at origin, ray from -5 along +x hits at t=4
    send_ray(mk(-5 * One, 0, 0, One, 0, 0, 0, 0, MaxI));
    begin
      hit_rec_t h;
      h = hits_pending[$];
      h.hit = 1; h.t = 4 * One; h.p[0] = -One; h.p[1] = 0; h.p[2] = 0;
      h.n[0] = -One; h.n[1] = 0; h.n[2] = 0; h.front = 1;
      hits_pending[$] = h;
    end
    directed = '{
      mk(0, 0, 0, One, 0, 0, 0, 0, MaxI),             // inside: back face
      mk(-5 * One, 0, 0, One, 0, 0, 0, 0, One),       // out of interval
      mk(-5 * One, 0, 0, One, 0, 0, 0, MaxI, MinI),   // reversed interval
      mk(-5 * One, 0, 0, One, 0, 0, 0, 5 * One, 5 * One),
      mk(-5 * One, 0, 0, 0, 0, 0, 0, MinI, MaxI),     // zero direction
      mk(-5 * One, 2 * One, 0, One, 0, 0, 0, MinI, MaxI), // miss
      mk(-5 * One, One, 0, One, 0, 0, 0, MinI, MaxI),     // tangent
      mk(MaxI, MaxI, MaxI, MinI, MinI, MinI, MaxI, MinI, MaxI),
      mk(MinI, MinI, MinI, MaxI, MaxI, MaxI, MinI, MinI, MaxI),
      mk(MaxI, MinI, 0, -1, 1, 0, 0, MinI, MaxI),
      mk(0, 0, 5 * One, 0, 0, -1, One, MinI, MaxI),
      mk(0, -3 * One, 0, 0, MaxI, 0, 0, MinI, MaxI),
      mk(5 * One, 0, 0, -One, 0, 0, 0, 5 * One, MaxI), // far root past near
      mk(-1, -1, -1, -1, -1, -1, -1, -1, -1)
    };
    foreach (directed[i]) send_ray(directed[i]);
    drain();

    // moving sphere, zero radius, extreme registers
    write_reg(RegStartX, 0);
    write_reg(RegStartY, 0);
    write_reg(RegStartZ, 0);
    write_reg(RegEndX, 10 * One);
    write_reg(RegEndY, 0);
    write_reg(RegEndZ, 0);
    write_reg(RegRadius, 0);
    send_ray(mk(5 * One, 0, -5 * One, 0, 0, One, One / 2, MinI, MaxI));
    drain();
    write_reg(RegRadius, 2 * One);
    send_ray(mk(5 * One, 0, -5 * One, 0, 0, One, One / 2, MinI, MaxI));
    send_ray(mk(10 * One, 0, -5 * One, 0, 0, One, One, MinI, MaxI));
    send_ray(mk(0, 0, -5 * One, 0, 0, One, MinI, MinI, MaxI));
    drain();
    write_reg(RegStartX, MaxI);
    write_reg(RegEndX, MinI);
    write_reg(RegStartY, MinI);
    write_reg(RegEndY, MaxI);
    write_reg(RegRadius, 31'h7fffffff);
    for (int k = 0; k < 4; k++) send_ray(rnd_ray());
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      for (int i = 0; i < 3; i++) begin
        write_reg(RegStartX + 3'(i), rnd_val());
        write_reg(RegEndX + 3'(i), rnd_val());
      end
      write_reg(RegRadius, (ph == 4) ? 1 : $urandom_range(One / 4, 6 * One));
      idle_pct = (ph == 2) ? 0 : 32;
      for (int k = 0; k < NumRandom / 5; k++) send_ray(rnd_ray());
      drain();
    end
    stim_done = 1;
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== moving_sphere_ray_hit_unit.f =====
rtl/msrh_pkg.sv
rtl/msrh_delay.sv
rtl/msrh_div.sv
rtl/msrh_sqrt.sv
rtl/msrh_fifo.sv
rtl/msrh_front.sv
rtl/msrh_back.sv
rtl/moving_sphere_ray_hit_unit.sv
tb/moving_sphere_ray_hit_unit_test.sv
